// File: sv/ysd_pkg.sv
package ysd_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCOUNT_W = 2;

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_JUMP_TIMEOUT   = 2'd0,
        REG_MIN_JUMP_SIZE  = 2'd1,
        REG_MIN_JUMP_COUNT = 2'd2
    } reg_index_t;

    localparam logic [31:0] TIMEOUT_RESET = 32'd500;
    localparam logic [15:0] JUMP_SIZE_RESET = 16'd100;
    localparam logic [7:0] JUMP_COUNT_RESET = 8'd2;

    localparam logic [15:0] JUMP_COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic [31:0]        time_ms;
    } item_t;

    typedef struct packed {
        logic [31:0] jump_timeout_ms;
        logic [15:0] min_jump_size;
        logic [7:0]  min_jump_count;
    } cfg_t;

    typedef struct packed {
        logic spinning;
        logic fire_ok;
        logic jump_now;
    } result_t;

endpackage

// File: sv/yaw_jump_spin_detector_core.sv
// Spin detector for a tracked target: each input transfer carries one yaw sample and its
// millisecond timestamp, and each produces exactly one result transfer with the spinning
// flag, the fire permission and whether the sample was counted as a jump. A two-entry
// queue takes input transfers while the engine works, so the input stays ready until
// the queue is full. The engine works on one sample at a time: judge and state update,
// the idle-time by jump-count multiply, the scaling by ten, and the final compare. It holds
// a finished result until the output register is free and takes no new sample meanwhile.
// The thresholds are set through the APB port at addresses 0x0, 0x4 and 0x8, and
// should only be written while no sample is in flight.
module yaw_jump_spin_detector_core #(
    parameter int JUDGE_FILL = 2,
    parameter int WINDOW_FILL = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ysd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [15:0]          s_yaw_angle,
    input  logic [31:0]                 s_time_ms,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_spinning,
    output logic                        m_fire_ok,
    output logic                        m_jump_now
);

    ysd_pkg::cfg_t      cfg_reg;
    ysd_pkg::cfg_t      cfg_next;
    ysd_pkg::item_t     s_item;
    ysd_pkg::item_t     q_item;
    ysd_pkg::result_t   m_result;
    ysd_pkg::reg_index_t reg_index;
    logic               cfg_write;
    logic               q_valid;
    logic               q_pop;

    assign pready    = 1'b1;
    assign reg_index = ysd_pkg::reg_index_t'(paddr[ysd_pkg::ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (reg_index)
                ysd_pkg::REG_JUMP_TIMEOUT:   cfg_next.jump_timeout_ms = pwdata;
                ysd_pkg::REG_MIN_JUMP_SIZE:  cfg_next.min_jump_size = pwdata[15:0];
                ysd_pkg::REG_MIN_JUMP_COUNT: cfg_next.min_jump_count = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            ysd_pkg::REG_JUMP_TIMEOUT:   prdata = cfg_reg.jump_timeout_ms;
            ysd_pkg::REG_MIN_JUMP_SIZE:  prdata = {16'd0, cfg_reg.min_jump_size};
            ysd_pkg::REG_MIN_JUMP_COUNT: prdata = {24'd0, cfg_reg.min_jump_count};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.jump_timeout_ms <= ysd_pkg::TIMEOUT_RESET;
            cfg_reg.min_jump_size   <= ysd_pkg::JUMP_SIZE_RESET;
            cfg_reg.min_jump_count  <= ysd_pkg::JUMP_COUNT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_item.yaw_angle = s_yaw_angle;
    assign s_item.time_ms   = s_time_ms;

    ysd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    ysd_back #(
        .JUDGE_FILL  (JUDGE_FILL),
        .WINDOW_FILL (WINDOW_FILL)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_spinning = m_result.spinning;
    assign m_fire_ok  = m_result.fire_ok;
    assign m_jump_now = m_result.jump_now;

    // Firing is only ever withheld while the target is judged to be spinning.
    a_fire_needs_spin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_spinning || m_fire_ok))
        else $error("fire_ok low without spinning");

    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("engine popped an empty queue");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result transfer pending right after reset");

endmodule

// File: sv/ysd_front.sv
module ysd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ysd_pkg::item_t s_item,
    output logic           q_valid,
    output ysd_pkg::item_t q_item,
    input  logic           q_pop
);

    ysd_pkg::item_t entry_reg [ysd_pkg::QUEUE_DEPTH];
    logic [ysd_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [ysd_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [ysd_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [ysd_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [ysd_pkg::QCOUNT_W-1:0] count_reg;
    logic [ysd_pkg::QCOUNT_W-1:0] count_next;
    logic                         push;
    logic                         pop;

    assign s_ready = count_reg < ysd_pkg::QCOUNT_W'(ysd_pkg::QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

// File: sv/ysd_back.sv
module ysd_back #(
    parameter int JUDGE_FILL = 2,
    parameter int WINDOW_FILL = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ysd_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  ysd_pkg::item_t   q_item,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output ysd_pkg::result_t m_result
);

    localparam int FILL_W = $clog2(WINDOW_FILL + 1);
    localparam int HELD_W = $clog2(WINDOW_FILL + JUDGE_FILL + 1);

    typedef enum logic [1:0] {
        S_JUDGE,
        S_MUL,
        S_SCALE,
        S_FINISH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic signed [15:0] prev_yaw_reg;
    logic signed [15:0] prev_yaw_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [15:0]        count_reg;
    logic [15:0]        count_next;
    logic [31:0]        first_reg;
    logic [31:0]        first_next;
    logic [31:0]        last_reg;
    logic [31:0]        last_next;
    logic               neg_reg;
    logic               neg_next;
    logic               spin_reg;
    logic               spin_next;
    logic [31:0]        now_reg;
    logic [31:0]        now_next;
    logic               jump_reg;
    logic               jump_next;
    logic [47:0]        prod_reg;
    logic [47:0]        prod_next;
    logic [33:0]        span3_reg;
    logic [33:0]        span3_next;
    logic [51:0]        lhs_reg;
    logic [51:0]        lhs_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    ysd_pkg::result_t   out_result_reg;
    ysd_pkg::result_t   out_result_next;

    logic               clear;
    logic signed [15:0] prev_c;
    logic [FILL_W-1:0]  fill_c;
    logic [15:0]        count_c;
    logic [31:0]        first_c;
    logic [31:0]        last_c;
    logic               neg_c;
    logic               spin_c;
    logic [HELD_W-1:0]  held;
    logic               judge;
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic               jump;
    logic [15:0]        count_inc;
    logic [31:0]        idle;
    logic [31:0]        span;
    logic               fire;

    assign clear = (count_reg != '0) &&
                   ((q_item.time_ms - last_reg) > cfg.jump_timeout_ms);

    assign prev_c  = clear ? '0 : prev_yaw_reg;
    assign fill_c  = clear ? '0 : fill_reg;
    assign count_c = clear ? '0 : count_reg;
    assign first_c = clear ? '0 : first_reg;
    assign last_c  = clear ? '0 : last_reg;
    assign neg_c   = clear ? 1'b0 : neg_reg;
    assign spin_c  = clear ? 1'b0 : spin_reg;

    assign held  = HELD_W'(fill_c) + HELD_W'(1);
    assign judge = held >= HELD_W'(JUDGE_FILL);
    assign diff  = {q_item.yaw_angle[15], q_item.yaw_angle} - {prev_c[15], prev_c};
    assign mag   = diff[16] ? 17'(17'd0 - diff) : 17'(diff);
    assign jump  = judge && (mag > {1'b0, cfg.min_jump_size});
    assign count_inc = (count_c == ysd_pkg::JUMP_COUNT_MAX) ? count_c : count_c + 16'd1;

    assign idle = now_reg - last_reg;
    assign span = last_reg - first_reg;
    assign fire = !spin_reg || ((count_reg >= 16'd2) && (lhs_reg < {18'd0, span3_reg}));

    assign q_pop    = (state_reg == S_JUDGE) && q_valid;
    assign m_valid  = out_valid_reg;
    assign m_result = out_result_reg;

    always_comb begin
        state_next      = state_reg;
        prev_yaw_next   = prev_yaw_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        neg_next        = neg_reg;
        spin_next       = spin_reg;
        now_next        = now_reg;
        jump_next       = jump_reg;
        prod_next       = prod_reg;
        span3_next      = span3_reg;
        lhs_next        = lhs_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_result_next = out_result_reg;
        case (state_reg)
            S_JUDGE: begin
                if (q_valid) begin
                    prev_yaw_next = q_item.yaw_angle;
                    fill_next     = (held > HELD_W'(WINDOW_FILL)) ?
                                    FILL_W'(WINDOW_FILL) : held[FILL_W-1:0];
                    count_next    = count_c;
                    first_next    = first_c;
                    last_next     = last_c;
                    neg_next      = neg_c;
                    spin_next     = spin_c;
                    if (jump) begin
                        if (count_c == '0) begin
                            first_next = q_item.time_ms;
                        end
                        last_next  = q_item.time_ms;
                        count_next = count_inc;
                        if ((count_inc > {8'd0, cfg.min_jump_count}) && (diff[16] == neg_c)) begin
                            spin_next = 1'b1;
                        end
                        neg_next = diff[16];
                    end
                    now_next   = q_item.time_ms;
                    jump_next  = jump;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = idle * count_reg;
                span3_next = {1'b0, span, 1'b0} + {2'b00, span};
                state_next = S_SCALE;
            end
            S_SCALE: begin
                lhs_next   = {1'b0, prod_reg, 3'b000} + {3'b000, prod_reg, 1'b0};
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next           = 1'b1;
                    out_result_next.spinning = spin_reg;
                    out_result_next.fire_ok  = fire;
                    out_result_next.jump_now = jump_reg;
                    state_next               = S_JUDGE;
                end
            end
            default: begin
                state_next = S_JUDGE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_JUDGE;
            prev_yaw_reg  <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            neg_reg       <= 1'b0;
            spin_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prev_yaw_reg  <= prev_yaw_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            neg_reg       <= neg_next;
            spin_reg      <= spin_next;
            out_valid_reg <= out_valid_next;
        end
        now_reg        <= now_next;
        jump_reg       <= jump_next;
        prod_reg       <= prod_next;
        span3_reg      <= span3_next;
        lhs_reg        <= lhs_next;
        out_result_reg <= out_result_next;
    end

endmodule

// File: sim/tb_yaw_jump_spin_detector_core.sv
`timescale 1ns / 1ps

module tb_yaw_jump_spin_detector_core;

    localparam int JUDGE_FILL = 2;
    localparam int WINDOW_FILL = 4;
    localparam int STALL_LIMIT = 4000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ysd_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [15:0] s_yaw_angle = '0;
    logic [31:0] s_time_ms = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_spinning;
    logic        m_fire_ok;
    logic        m_jump_now;

    yaw_jump_spin_detector_core #(
        .JUDGE_FILL(JUDGE_FILL),
        .WINDOW_FILL(WINDOW_FILL)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_yaw_angle(s_yaw_angle),
        .s_time_ms(s_time_ms),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_spinning(m_spinning),
        .m_fire_ok(m_fire_ok),
        .m_jump_now(m_jump_now)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    ysd_pkg::item_t   yaw_frames[$];
    ysd_pkg::result_t spin_results_due[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      quiet_cycles = 0;

    ysd_pkg::cfg_t thresholds = '{ysd_pkg::TIMEOUT_RESET, ysd_pkg::JUMP_SIZE_RESET,
                                  ysd_pkg::JUMP_COUNT_RESET};

    logic signed [15:0] trk_prev_yaw = '0;
    int                 trk_fill = 0;
    logic [15:0]        trk_count = '0;
    logic [31:0]        trk_first = '0;
    logic [31:0]        trk_last = '0;
    logic               trk_neg = 1'b0;
    logic               trk_spin = 1'b0;

    logic signed [15:0] gen_yaw = '0;
    logic [31:0]        gen_stamp = '0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic void clear_tracker();
        trk_prev_yaw = '0;
        trk_fill = 0;
        trk_count = '0;
        trk_first = '0;
        trk_last = '0;
        trk_neg = 1'b0;
        trk_spin = 1'b0;
    endfunction

    function automatic void predict_spin_result(input logic signed [15:0] yaw,
                                                input logic [31:0] now);
        logic [31:0] since;
        int          diff;
        int          mag;
        logic        neg;
        logic        jump;
        logic        fire;
        logic [63:0] idle;
        logic [63:0] span;
        ysd_pkg::result_t res;
        jump = 1'b0;
        fire = 1'b1;
        since = now - trk_last;
        if (trk_count != 0 && since > thresholds.jump_timeout_ms) begin
            clear_tracker();
        end
        if (trk_fill + 1 >= JUDGE_FILL) begin
            diff = int'(yaw) - int'(trk_prev_yaw);
            mag = (diff < 0) ? -diff : diff;
            if (mag > int'({16'd0, thresholds.min_jump_size})) begin
                neg = (diff < 0);
                jump = 1'b1;
                if (trk_count == 0) begin
                    trk_first = now;
                end
                trk_last = now;
                if (trk_count < ysd_pkg::JUMP_COUNT_MAX) begin
                    trk_count = trk_count + 16'd1;
                end
                if (trk_count > {8'd0, thresholds.min_jump_count} && neg == trk_neg) begin
                    trk_spin = 1'b1;
                end
                trk_neg = neg;
            end
        end
        trk_prev_yaw = yaw;
        trk_fill = (trk_fill + 1 > WINDOW_FILL) ? WINDOW_FILL : trk_fill + 1;
        if (trk_spin) begin
            idle = {32'd0, now - trk_last};
            span = {32'd0, trk_last - trk_first};
            fire = (trk_count >= 16'd2) && (64'd10 * idle * trk_count < 64'd3 * span);
        end
        res.spinning = trk_spin;
        res.fire_ok = fire;
        res.jump_now = jump;
        spin_results_due.insert(spin_results_due.size(), res);
    endfunction

    always @(posedge aclk) begin
        ysd_pkg::item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_spin_result(s_yaw_angle, s_time_ms);
            end
            if (!s_valid || s_ready) begin
                if (yaw_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = yaw_frames.pop_front();
                    s_valid <= 1'b1;
                    s_yaw_angle <= nxt.yaw_angle;
                    s_time_ms <= nxt.time_ms;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        ysd_pkg::result_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (spin_results_due.size() == 0) begin
                    report_mismatch("result transfer with no sample waiting");
                end else begin
                    due = spin_results_due.pop_front();
                    if (m_spinning !== due.spinning)
                        report_mismatch($sformatf("spinning %b, expected %b",
                                                  m_spinning, due.spinning));
                    if (m_fire_ok !== due.fire_ok)
                        report_mismatch($sformatf("fire_ok %b, expected %b",
                                                  m_fire_ok, due.fire_ok));
                    if (m_jump_now !== due.jump_now)
                        report_mismatch($sformatf("jump_now %b, expected %b",
                                                  m_jump_now, due.jump_now));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] index, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            ysd_pkg::REG_JUMP_TIMEOUT: thresholds.jump_timeout_ms = data;
            ysd_pkg::REG_MIN_JUMP_SIZE: thresholds.min_jump_size = data[15:0];
            ysd_pkg::REG_MIN_JUMP_COUNT: thresholds.min_jump_count = data[7:0];
            default: ;
        endcase
    endtask

    task automatic apb_check(input logic [1:0] index, input logic [31:0] want);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {index, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d reads %h, expected %h",
                                      index, prdata, want));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_thresholds(input ysd_pkg::cfg_t c);
        apb_write(ysd_pkg::REG_JUMP_TIMEOUT, c.jump_timeout_ms);
        apb_write(ysd_pkg::REG_MIN_JUMP_SIZE, {16'($urandom), c.min_jump_size});
        apb_write(ysd_pkg::REG_MIN_JUMP_COUNT, {24'($urandom), c.min_jump_count});
        apb_write(REG_UNUSED, $urandom);
        apb_check(ysd_pkg::REG_JUMP_TIMEOUT, thresholds.jump_timeout_ms);
        apb_check(ysd_pkg::REG_MIN_JUMP_SIZE, {16'd0, thresholds.min_jump_size});
        apb_check(ysd_pkg::REG_MIN_JUMP_COUNT, {24'd0, thresholds.min_jump_count});
    endtask

    task automatic wait_drained();
        while (yaw_frames.size() > 0 || s_valid || spin_results_due.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic queue_frame(input logic signed [15:0] yaw, input logic [31:0] stamp);
        ysd_pkg::item_t f;
        f.yaw_angle = yaw;
        f.time_ms = stamp;
        yaw_frames.insert(yaw_frames.size(), f);
    endtask

    task automatic make_traffic(input int n);
        int left;
        int kind;
        int run_len;
        int every;
        int step;
        int dir;
        left = n;
        while (left > 0) begin
            kind = $urandom_range(99);
            run_len = $urandom_range(40, 8);
            if (run_len > left) run_len = left;
            dir = $urandom_range(1) ? 1 : -1;
            every = $urandom_range(4, 1);
            for (int i = 0; i < run_len; i++) begin
                if (kind < 60) begin
                    if (i % every == 0) begin
                        step = int'(thresholds.min_jump_size) + int'($urandom_range(300));
                        gen_yaw = 16'(int'(gen_yaw) + dir * step);
                        if ($urandom_range(9) == 0) dir = -dir;
                    end else begin
                        step = int'($urandom_range(thresholds.min_jump_size / 2));
                        gen_yaw = $urandom_range(1) ? 16'(int'(gen_yaw) + step)
                                                    : 16'(int'(gen_yaw) - step);
                    end
                    gen_stamp = gen_stamp + $urandom_range(60);
                end else if (kind < 85) begin
                    gen_yaw = 16'($urandom);
                    if ($urandom_range(4) == 0) gen_stamp = $urandom;
                    else gen_stamp = gen_stamp + $urandom_range(1000);
                end else begin
                    if (i == 0) gen_stamp = gen_stamp + thresholds.jump_timeout_ms
                                            + $urandom_range(1);
                    else gen_stamp = gen_stamp + $urandom_range(20);
                    gen_yaw = 16'($urandom);
                end
                queue_frame(gen_yaw, gen_stamp);
            end
            left -= run_len;
        end
    endtask

    initial begin
        ysd_pkg::cfg_t plan[6];
        int   seg_items;
        plan[0] = '{32'd1000, 16'd100, 8'd2};
        plan[1] = '{32'hFFFF_FFFF, 16'd0, 8'd0};
        plan[2] = '{32'd0, 16'hFFFF, 8'hFF};
        plan[3] = '{32'd300, 16'd2000, 8'd1};
        plan[4] = '{32'($urandom_range(2000, 50)), 16'($urandom_range(1000)),
                    8'($urandom_range(6))};
        plan[5] = '{32'd800, 16'd500, 8'd3};
        seg_items = 172;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 70;
        apb_check(ysd_pkg::REG_JUMP_TIMEOUT, {ysd_pkg::TIMEOUT_RESET});
        apb_check(ysd_pkg::REG_MIN_JUMP_SIZE, {16'd0, ysd_pkg::JUMP_SIZE_RESET});
        apb_check(ysd_pkg::REG_MIN_JUMP_COUNT, {24'd0, ysd_pkg::JUMP_COUNT_RESET});

        // The first sample is never judged, however far it lies from zero.
        queue_frame(16'sh7FFF, 32'd0);
        queue_frame(-16'sd32768, 32'd10);
        queue_frame(-16'sd32667, 32'd20);
        queue_frame(-16'sd32567, 32'd30);
        queue_frame(-16'sd32417, 32'd40);
        queue_frame(-16'sd32417, 32'd45);
        queue_frame(-16'sd32417, 32'd41);
        // Idle time exactly at the timeout keeps the state; one more clears it.
        queue_frame(-16'sd32417, 32'd540);
        queue_frame(-16'sd32417, 32'd541);
        // Three jumps at one timestamp give a zero jump period.
        queue_frame(-16'sd32217, 32'd541);
        queue_frame(-16'sd32017, 32'd541);
        queue_frame(-16'sd31817, 32'd541);
        // Jump times that straddle the wrap of the millisecond counter.
        queue_frame(16'sd0, 32'hFFFF_FFF0);
        queue_frame(-16'sd200, 32'hFFFF_FFF8);
        queue_frame(-16'sd400, 32'h0000_0004);
        queue_frame(-16'sd600, 32'h0000_000A);
        queue_frame(-16'sd600, 32'h0000_000C);
        queue_frame(16'sd0, 32'hFFFF_FFFF);
        wait_drained();

        gen_stamp = 32'hFFFF_F000;
        for (int s = 0; s < 6; s++) begin
            if (s < 2) begin
                send_idle_pct = 37;
                recv_idle_pct = 70;
            end else if (s < 4) begin
                send_idle_pct = 70;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            program_thresholds(plan[s]);
            make_traffic(seg_items / 2);
            wait_drained();
            make_traffic(seg_items - seg_items / 2);
            wait_drained();
        end

        // A run of steady jumps in one direction keeps the spin flag latched.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_thresholds('{32'hFFFF_FFFF, 16'd100, 8'd2});
        for (int k = 0; k < 20; k++) begin
            if ($urandom_range(7) != 0) gen_yaw = gen_yaw + 16'sd200;
            gen_stamp = gen_stamp + $urandom_range(3, 1);
            queue_frame(gen_yaw, gen_stamp);
        end
        wait_drained();

        repeat (16) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/ysd_pkg.sv
sv/ysd_front.sv
sv/ysd_back.sv
sv/yaw_jump_spin_detector_core.sv
sim/tb_yaw_jump_spin_detector_core.sv
